// ===== hdl/lsp_pkg.sv =====
package lsp_pkg;

    // Sample memory geometry.
    localparam int MAX_SAMPLES = 65536;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_BEGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0]  VOLUME_RESET = 8'd100;
    localparam logic [16:0] COUNT_RESET  = 17'd1;

    // Division by 100 as a reciprocal multiply: exact for magnitudes below 2^15.
    localparam int RECIP_MUL   = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;

    // Input op codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        MODE_CONT    = 2'd0,
        MODE_ONESHOT = 2'd1,
        MODE_LOOP    = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    // What the output stage does with a tick.
    typedef enum logic [1:0] {
        K_ZERO = 2'd0,   // output zero
        K_PLAY = 2'd1,   // output the scaled sample
        K_KEEP = 2'd2,   // output the scaled sample and remember it
        K_HELD = 2'd3    // output the remembered sample
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic        trigger_clear;
        logic        latch_clear;
    } t_tick;

    typedef struct packed {
        logic              op;
        logic [15:0]       sample_address;
        logic signed [7:0] sample_value;
        logic              trigger;
        logic              latch;
    } t_in_item;

    typedef struct packed {
        logic signed [8:0] audio_out;
        logic              trigger_clear;
        logic              latch_clear;
    } t_out_item;

    // Map a 16-bit position or address onto the memory index range.
    function automatic logic [ADDR_W-1:0] to_addr(input logic [15:0] a);
        logic [ADDR_W+15:0] wide;
        wide = {{ADDR_W{1'b0}}, a};
        return wide[ADDR_W-1:0];
    endfunction

endpackage

// ===== hdl/lsp_sample_ram.sv =====
module lsp_sample_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [lsp_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic                      i_re,
    input  logic [lsp_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);
    import lsp_pkg::*;

    logic [7:0] r_mem [MAX_SAMPLES];
    logic [7:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lsp_ctrl.sv =====
module lsp_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_advance,
    input  lsp_pkg::t_in_item             i_item,
    output lsp_pkg::t_tick                o_tick,
    output logic [7:0]                    o_volume,
    output logic                          o_we,
    output logic [lsp_pkg::ADDR_W-1:0]    o_waddr,
    output logic [lsp_pkg::ADDR_W-1:0]    o_raddr
);
    import lsp_pkg::*;

    logic [7:0]  r_volume;
    logic [16:0] r_count;
    logic [15:0] r_loop_begin;
    logic [16:0] r_loop_end;
    t_mode       r_mode;

    logic [15:0] r_pos;
    logic [15:0] n_pos;
    t_tick       r_tick;
    t_tick       n_tick;

    logic [16:0] pos_inc;
    logic        can_play;
    logic        tick_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume     <= VOLUME_RESET;
            r_count      <= COUNT_RESET;
            r_loop_begin <= '0;
            r_loop_end   <= '0;
            r_mode       <= MODE_CONT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VOLUME:     r_volume     <= i_cfg_data[7:0];
                REG_COUNT:      r_count      <= i_cfg_data[16:0];
                REG_LOOP_BEGIN: r_loop_begin <= i_cfg_data[15:0];
                REG_LOOP_END:   r_loop_end   <= i_cfg_data[16:0];
                REG_MODE:       r_mode       <= t_mode'(i_cfg_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    assign tick_accept = i_accept && (i_item.op == OP_TICK);
    assign pos_inc     = {1'b0, r_pos} + 17'd1;
    assign can_play    = pos_inc < r_count;

    // Per-tick decision: next position and what the output stage must do.
    always_comb begin
        n_pos               = r_pos;
        n_tick.valid        = tick_accept;
        n_tick.kind         = K_ZERO;
        n_tick.trigger_clear = 1'b0;
        n_tick.latch_clear  = 1'b0;
        unique case (r_mode)
            MODE_CONT: begin
                if (can_play) begin
                    n_pos       = pos_inc[15:0];
                    n_tick.kind = K_KEEP;
                end else begin
                    n_pos       = '0;
                    n_tick.kind = K_HELD;
                end
            end
            MODE_ONESHOT: begin
                priority if (!i_item.trigger) begin
                    n_pos = '0;
                end else if (can_play) begin
                    n_pos       = pos_inc[15:0];
                    n_tick.kind = K_PLAY;
                end else begin
                    n_pos                = '0;
                    n_tick.trigger_clear = 1'b1;
                end
            end
            MODE_LOOP: begin
                priority if (!i_item.trigger && !i_item.latch) begin
                    n_pos = '0;
                end else if (can_play) begin
                    n_tick.kind = K_PLAY;
                    if (i_item.trigger && (pos_inc == r_loop_end)) begin
                        n_pos = r_loop_begin;
                    end else begin
                        n_pos = pos_inc[15:0];
                    end
                end else begin
                    n_pos              = '0;
                    n_tick.latch_clear = 1'b1;
                end
            end
            default: begin
                n_pos = '0;
            end
        endcase
    end

    // Position moves only on an accepted tick; the tick record moves with the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_tick.valid <= 1'b0;
        end else begin
            if (tick_accept) begin
                r_pos <= n_pos;
            end
            if (i_advance) begin
                r_tick <= n_tick;
            end
        end
    end

    assign o_tick   = r_tick;
    assign o_volume = r_volume;
    assign o_we     = i_accept && (i_item.op == OP_WRITE);
    assign o_waddr  = to_addr(i_item.sample_address);
    assign o_raddr  = to_addr(r_pos);

endmodule

// ===== hdl/lsp_scale.sv =====
module lsp_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsp_pkg::t_tick     i_tick,
    input  logic [7:0]         i_sample,
    input  logic [7:0]         i_volume,
    input  logic               i_out_stall,
    output logic               o_advance,
    output logic               o_out_valid,
    output lsp_pkg::t_out_item o_out_data
);
    import lsp_pkg::*;

    localparam int QMUL_W = 16 + RECIP_W;

    t_tick              r_s2_tick;
    logic signed [16:0] r_s2_prod;
    t_tick              r_s3_tick;
    logic [8:0]         r_s3_mag;
    logic               r_s3_neg;
    logic               r_out_valid;
    t_out_item          r_out_data;
    logic signed [8:0]  r_held;

    logic               advance;
    logic               prod_neg;
    logic [15:0]        prod_mag;
    logic [QMUL_W-1:0]  qmul;
    logic signed [8:0]  scaled;
    logic signed [8:0]  n_audio;

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance = !r_out_valid || !i_out_stall;

    assign prod_neg = r_s2_prod[16];
    assign prod_mag = prod_neg ? 16'(-r_s2_prod) : r_s2_prod[15:0];
    assign qmul     = QMUL_W'(prod_mag) * QMUL_W'(RECIP_MUL);

    // Saturate the signed quotient to nine bits and pick the output by tick kind.
    always_comb begin
        if (r_s3_neg) begin
            scaled = (r_s3_mag > 9'd256) ? -9'sd256 : -$signed(r_s3_mag);
        end else begin
            scaled = (r_s3_mag > 9'd255) ? 9'sd255 : $signed(r_s3_mag);
        end
        unique case (r_s3_tick.kind)
            K_PLAY, K_KEEP: n_audio = scaled;
            K_HELD:         n_audio = r_held;
            default:        n_audio = '0;
        endcase
    end

    // Multiply, divide by 100 and select, one step per stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tick.valid <= 1'b0;
            r_s3_tick.valid <= 1'b0;
            r_out_valid     <= 1'b0;
            r_held          <= '0;
        end else if (advance) begin
            r_s2_tick <= i_tick;
            r_s2_prod <= 17'($signed(i_sample)) * 17'($signed({1'b0, i_volume}));
            r_s3_tick <= r_s2_tick;
            r_s3_neg  <= prod_neg;
            r_s3_mag  <= qmul[RECIP_SHIFT+8:RECIP_SHIFT];
            r_out_valid              <= r_s3_tick.valid;
            r_out_data.audio_out     <= n_audio;
            r_out_data.trigger_clear <= r_s3_tick.trigger_clear;
            r_out_data.latch_clear   <= r_s3_tick.latch_clear;
            if (r_s3_tick.valid && (r_s3_tick.kind == K_KEEP)) begin
                r_held <= scaled;
            end
        end
    end

    assign o_advance   = advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/looped_sample_player.sv =====
// Sample player with loop points. Write beats (op set) load one signed 8-bit
// sample into a 64K-entry sample memory; tick beats (op clear) each return one
// result beat holding, per mode, the sample at the play position scaled by
// volume/100, a held earlier result or zero, then step the position by the
// selected mode (continuous, one-shot, or loop with latch). One beat is
// accepted per clock while the output register is empty or not stalled. The
// memory is read at the edge that accepts a tick; the volume multiply, the
// reciprocal divide-by-100 and the output register then follow as stages.
// The memory needs no clearing after reset: only written samples may be played.
// Configuration writes must be made while no tick is in flight.
module looped_sample_player (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lsp_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lsp_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [lsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lsp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsp_pkg::*;

    logic              advance;
    logic              accept;
    t_tick             tick;
    logic [7:0]        volume;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    assign o_in_stall = !advance;
    assign accept     = i_in_valid && advance;

    lsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_advance  (advance),
        .i_item     (i_in_data),
        .o_tick     (tick),
        .o_volume   (volume),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_raddr    (mem_raddr)
    );

    lsp_sample_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in_data.sample_value),
        .i_re    (advance),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lsp_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_sample    (mem_rdata),
        .i_volume    (volume),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/lsp_checker.sv =====
module lsp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  lsp_pkg::t_out_item o_out_data
);
    import lsp_pkg::*;

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // Input is held off only behind a stalled, full output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // One-shot and loop endings are never reported together.
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.trigger_clear && o_out_data.latch_clear))
        else $error("both clear flags set");

    // An end-of-play beat carries silence.
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.trigger_clear || o_out_data.latch_clear)
        |-> o_out_data.audio_out == 9'sd0)
        else $error("end-of-play beat carries audio");

endmodule

bind looped_sample_player lsp_checker u_lsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
